// ----- rtl/core/plc_pkg.sv -----
`default_nettype none
package plc_pkg;

   localparam int Capacity   = 32;
   localparam int DataW      = 32;
   localparam int MaxResults = 32;

   localparam int IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
   localparam int CntW = $clog2(Capacity + 1);
   localparam int CmpW = ((CntW > 6) ? CntW : 6) + 1;

   localparam logic [2:0] CMD_READ      = 3'd0;
   localparam logic [2:0] CMD_INS_FRONT = 3'd1;
   localparam logic [2:0] CMD_INS_END   = 3'd2;
   localparam logic [2:0] CMD_INS_AT    = 3'd3;
   localparam logic [2:0] CMD_DEL_FIRST = 3'd4;
   localparam logic [2:0] CMD_DEL_LAST  = 3'd5;
   localparam logic [2:0] CMD_DEL_AT    = 3'd6;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_BADPOS = 2'd3;

   localparam logic [1:0] MODE_HOLD = 2'd0;
   localparam logic [1:0] MODE_INS  = 2'd1;
   localparam logic [1:0] MODE_DEL  = 2'd2;
   localparam logic [1:0] MODE_ROT  = 2'd3;

   typedef logic [DataW-1:0] word_type;

   typedef struct packed {
      logic [1:0]      mode;
      logic [IdxW-1:0] idx;
      logic [IdxW-1:0] last;
      word_type        word;
   } plc_ctl_type;

   function automatic logic signed [31:0] to_out(input word_type w);
      logic signed [DataW-1:0] s;
      s = w;
      return 32'(s);
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/plc_cell.sv -----
`default_nettype none
module plc_cell (
   input  wire logic                    clock,
   input  wire logic [plc_pkg::IdxW-1:0] cell_idx,
   input  wire plc_pkg::plc_ctl_type    ctl,
   input  wire plc_pkg::word_type       left_word,
   input  wire plc_pkg::word_type       right_word,
   input  wire plc_pkg::word_type       head_word,
   output plc_pkg::word_type            word_out
);
   import plc_pkg::*;

   word_type word_ff;
   word_type word_in;

   always_comb begin
      word_in = word_ff;
      case (ctl.mode)
         MODE_INS: begin
            if (cell_idx == ctl.idx) begin
               word_in = ctl.word;
            end else if (cell_idx > ctl.idx) begin
               word_in = left_word;
            end
         end
         MODE_DEL: begin
            if (cell_idx >= ctl.idx) begin
               word_in = right_word;
            end
         end
         MODE_ROT: begin
            if (cell_idx < ctl.last) begin
               word_in = right_word;
            end else if (cell_idx == ctl.last) begin
               word_in = head_word;
            end
         end
         default: word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;

endmodule
`default_nettype wire

// ----- rtl/core/plc_chain.sv -----
`default_nettype none
module plc_chain (
   input  wire logic                 clock,
   input  wire plc_pkg::plc_ctl_type ctl,
   output plc_pkg::word_type         head_word
);
   import plc_pkg::*;

   word_type cell_word [Capacity];

   for (genvar i = 0; i < Capacity; i++) begin : g_cell
      word_type left_w;
      word_type right_w;

      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_word[i-1];
      end

      if (i == Capacity - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = cell_word[i+1];
      end

      plc_cell u_cell (
         .clock      (clock),
         .cell_idx   (IdxW'(i)),
         .ctl        (ctl),
         .left_word  (left_w),
         .right_word (right_w),
         .head_word  (cell_word[0]),
         .word_out   (cell_word[i])
      );
   end

   assign head_word = cell_word[0];

endmodule
`default_nettype wire

// ----- rtl/core/positional_list_store.sv -----
// Channel   Direction  Handshake          Word
// req       in         req_valid/stall    command, value, position
// rsp       out        rsp_valid/stall    entry_value, status, entry_count, has_entry,
//                                         last_of_run
// An edit shifts every cell at or past the edit position at once, and the status word is registered with it.
// Read streams all entries, one per cycle while rsp is not stalled, by rotating the chain;
// req_stall stays high until the run ends.
// Reset is synchronous and empties the list; cell contents are not cleared.
// A stalled rsp word holds; a new req word is taken once the output register is free and no read is running.
`default_nettype none
module positional_list_store (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_command,
   input  wire logic signed [31:0] req_value,
   input  wire logic [5:0]         req_position,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_entry_value,
   output logic [1:0]              rsp_status,
   output logic [5:0]              rsp_entry_count,
   output logic                    rsp_has_entry,
   output logic                    rsp_last_of_run
);
   import plc_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;

   logic                 state_ff, state_in;
   logic [CntW-1:0]      count_ff, count_in;
   logic [CntW-1:0]      step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]   rsp_value_ff, rsp_value_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [5:0]           rsp_count_ff, rsp_count_in;
   logic                 rsp_has_ff, rsp_has_in;
   logic                 rsp_last_ff, rsp_last_in;

   plc_ctl_type ctl;
   word_type    head_word;
   logic        rsp_free;
   logic        req_take;
   logic        full, empty;
   logic [CmpW-1:0] pos_c, cnt_c, step_c, rd_len;
   logic        emit;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff == S_READ) || !rsp_free;
   assign req_take  = req_valid && !req_stall;
   assign full      = (count_ff == CntW'(Capacity));
   assign empty     = (count_ff == '0);
   assign pos_c     = CmpW'(req_position);
   assign cnt_c     = CmpW'(count_ff);
   assign step_c    = CmpW'(step_ff);
   assign rd_len    = (cnt_c > CmpW'(MaxResults)) ? CmpW'(MaxResults) : cnt_c;
   assign emit      = step_c < rd_len;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_last_in   = rsp_last_ff;
      ctl.mode      = MODE_HOLD;
      ctl.idx       = '0;
      ctl.last      = IdxW'(count_ff - CntW'(1));
      ctl.word      = DataW'(req_value);

      if (state_ff == S_READ) begin
         if (rsp_free || !emit) begin
            ctl.mode = MODE_ROT;
            step_in  = step_ff + CntW'(1);
            if (step_ff == count_ff - CntW'(1)) begin
               state_in = S_IDLE;
            end
            if (emit) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = to_out(head_word);
               rsp_status_in = ST_OK;
               rsp_count_in  = 6'(count_ff);
               rsp_has_in    = 1'b1;
               rsp_last_in   = (step_c == rd_len - CmpW'(1));
            end
         end
      end else if (req_take) begin
         rsp_status_in = ST_OK;
         case (req_command)
            CMD_READ: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  state_in = S_READ;
                  step_in  = '0;
               end
            end
            CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT: begin
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else if (req_command == CMD_INS_FRONT) begin
                  ctl.mode = MODE_INS;
                  ctl.idx  = '0;
               end else if (req_command == CMD_INS_END) begin
                  ctl.mode = MODE_INS;
                  ctl.idx  = IdxW'(count_ff);
               end else if (pos_c == '0 || pos_c > cnt_c + CmpW'(1)) begin
                  rsp_status_in = ST_BADPOS;
               end else begin
                  ctl.mode = MODE_INS;
                  ctl.idx  = IdxW'(pos_c - CmpW'(1));
               end
               if (ctl.mode == MODE_INS) begin
                  count_in = count_ff + CntW'(1);
               end
            end
            CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AT: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
               end else if (req_command == CMD_DEL_FIRST) begin
                  ctl.mode = MODE_DEL;
                  ctl.idx  = '0;
               end else if (req_command == CMD_DEL_LAST) begin
                  ctl.mode = MODE_DEL;
                  ctl.idx  = IdxW'(count_ff - CntW'(1));
               end else if (pos_c == '0 || pos_c > cnt_c) begin
                  rsp_status_in = ST_BADPOS;
               end else begin
                  ctl.mode = MODE_DEL;
                  ctl.idx  = IdxW'(pos_c - CmpW'(1));
               end
               if (ctl.mode == MODE_DEL) begin
                  count_in = count_ff - CntW'(1);
               end
            end
            default: rsp_status_in = ST_OK;
         endcase
         if (state_in == S_IDLE) begin
            rsp_valid_in = 1'b1;
            rsp_value_in = '0;
            rsp_count_in = 6'(count_in);
            rsp_has_in   = 1'b0;
            rsp_last_in  = 1'b1;
         end
      end
   end

   plc_chain u_chain (
      .clock     (clock),
      .ctl       (ctl),
      .head_word (head_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_has_entry   = rsp_has_ff;
   assign rsp_last_of_run = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Capacity))
      else $error("entry count above capacity");

   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> !empty && step_ff < count_ff)
      else $error("read run past the list");

   a_edit_answers: assert property (@(posedge clock) disable iff (reset)
      req_take && req_command != CMD_READ |=> rsp_valid_ff && rsp_last_ff && !rsp_has_ff)
      else $error("edit gave no status word");

   a_count_steady_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |=> $stable(count_ff))
      else $error("count changed during read");

endmodule
`default_nettype wire
